/* sv/crs_pkg.sv */
package crs_pkg;

   // Grid limits
   localparam int GRID_DIM_MAX = 4;
   localparam int COORD_BITS   = 16;
   localparam int RANK_BITS    = 32;

   // Fixed field widths
   localparam int DIR_BITS      = 2;
   localparam int DISP_BITS     = 32;
   localparam int NDIM_BITS     = 3;
   localparam int PERIODIC_BITS = 4;
   localparam int CFG_BITS      = 64;
   localparam int ADDR_BITS     = 6;
   localparam int REG_IDX_BITS  = 3;

   // Shifted coordinate: coordinate plus or minus displacement, with sign
   localparam int TGT_BITS = DISP_BITS + 2;
   // Magnitude of the shifted coordinate always fits the displacement width
   localparam int MAG_BITS = DISP_BITS;

   // Remainder unit: bits consumed per pipeline stage
   localparam int REM_STEP   = 4;
   localparam int DIV_STAGES = MAG_BITS / REM_STEP;

   // Stride factors: sizes of the dimensions after the direction
   localparam int FAC_CNT       = (GRID_DIM_MAX > 1) ? GRID_DIM_MAX - 1 : 1;
   localparam int SLOT_IDX_BITS = 4;
   localparam int SLOT_CNT      = 1 << SLOT_IDX_BITS;
   localparam int DIR_CNT       = 1 << DIR_BITS;

   // Pipeline: entry, remainder stages, fixup, multiply, add
   localparam int FIX_STAGE  = DIV_STAGES + 1;
   localparam int MUL_STAGE  = DIV_STAGES + 2;
   localparam int ADD_STAGE  = DIV_STAGES + 3;
   localparam int NUM_STAGES = DIV_STAGES + 4;

   // Register indexes
   localparam logic [REG_IDX_BITS-1:0] REG_NUM_DIMS      = 3'd0;
   localparam logic [REG_IDX_BITS-1:0] REG_DIM_SIZES     = 3'd1;
   localparam logic [REG_IDX_BITS-1:0] REG_OWN_COORDS    = 3'd2;
   localparam logic [REG_IDX_BITS-1:0] REG_PERIODIC_MASK = 3'd3;
   localparam logic [REG_IDX_BITS-1:0] REG_OWN_RANK      = 3'd4;

   // Register reset values
   localparam logic [NDIM_BITS-1:0] RST_NUM_DIMS  = 3'd1;
   localparam logic [CFG_BITS-1:0]  RST_DIM_SIZES = 64'h0001_0001_0001_0001;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [RANK_BITS-1:0]  rank_type;

   // One neighbor (source or destination) as it moves down the pipe
   typedef struct packed {
      logic                neg;
      logic [MAG_BITS-1:0] mag;
      coord_type           rem;
      logic                inrange;
      rank_type            delta;
      logic                ok;
   } side_type;

   typedef struct packed {
      logic                     dirok;
      logic                     per;
      coord_type                coord;
      coord_type                size;
      coord_type [FAC_CNT-1:0]  fac;
      rank_type                 stride;
      side_type                 src;
      side_type                 dst;
   } stage_type;

endpackage

/* sv/crs_rem_step.sv */
module crs_rem_step
   import crs_pkg::*;
(
   input  coord_type             rem_cur,
   input  logic [REM_STEP-1:0]   bits_cur,
   input  coord_type             size_cur,
   output coord_type             rem_nxt
);

   // Restoring remainder: shift in one bit, subtract size when it fits
   always_comb begin : rem_chain
      logic [COORD_BITS:0] part;
      coord_type           acc;
      acc  = rem_cur;
      part = '0;
      for (int j = 0; j < REM_STEP; j++) begin
         part = {acc, bits_cur[REM_STEP-1-j]};
         if (part >= {1'b0, size_cur}) begin
            part = part - {1'b0, size_cur};
         end
         acc = part[COORD_BITS-1:0];
      end
      rem_nxt = acc;
   end

endmodule

/* sv/cartesian_rank_shift_top.sv */
// Neighbor rank lookup for a row-major Cartesian process grid.
// Request channel (req_*): a direction and a signed displacement. Response
// channel (rsp_*): source and destination ranks, each with a valid flag that
// is low for the null process (rank then reads zero).
// Grid shape, own coordinates, periodic flags and own rank sit in registers
// on an APB-style port at byte address 8*index, 64-bit data; write them only
// while no request is in flight.
// A request passes one entry stage, eight remainder stages (four bits of the
// shifted coordinate each, for the wrap in periodic dimensions), then fixup,
// multiply by stride, and add of the own rank on its way to the response.
// One request enters every cycle while req_stall is low.
// Each stage advances when its successor has room, so bubbles close up and
// requests keep being taken while a response waits. req_stall rises only
// when all twelve stages hold requests and the receiver stalls.
// Reset empties the pipe and returns the registers to a one-dimensional grid
// of size one, coordinate zero, rank zero, no wrap.
module cartesian_rank_shift_top
   import crs_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [DIR_BITS-1:0]         req_direction,
   input  logic signed [DISP_BITS-1:0] req_displacement,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [RANK_BITS-1:0]        rsp_source_rank,
   output logic                        rsp_source_valid,
   output logic [RANK_BITS-1:0]        rsp_dest_rank,
   output logic                        rsp_dest_valid,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [ADDR_BITS-1:0]        paddr,
   input  logic [CFG_BITS-1:0]         pwdata,
   output logic [CFG_BITS-1:0]         prdata,
   output logic                        pready
);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [NDIM_BITS-1:0]     num_dims_ff,   num_dims_in;
   logic [CFG_BITS-1:0]      dim_sizes_ff,  dim_sizes_in;
   logic [CFG_BITS-1:0]      own_coords_ff, own_coords_in;
   logic [PERIODIC_BITS-1:0] periodic_ff,   periodic_in;
   rank_type                 own_rank_ff,   own_rank_in;
   logic [REG_IDX_BITS-1:0]  reg_index;
   logic                     cfg_write;

   assign pready    = 1'b1;
   assign reg_index = paddr[ADDR_BITS-1:3];
   assign cfg_write = psel & penable & pwrite;

   // Decode the write
   always_comb begin
      num_dims_in   = num_dims_ff;
      dim_sizes_in  = dim_sizes_ff;
      own_coords_in = own_coords_ff;
      periodic_in   = periodic_ff;
      own_rank_in   = own_rank_ff;
      if (cfg_write) begin
         case (reg_index)
            REG_NUM_DIMS:      num_dims_in   = pwdata[NDIM_BITS-1:0];
            REG_DIM_SIZES:     dim_sizes_in  = pwdata;
            REG_OWN_COORDS:    own_coords_in = pwdata;
            REG_PERIODIC_MASK: periodic_in   = pwdata[PERIODIC_BITS-1:0];
            REG_OWN_RANK:      own_rank_in   = pwdata[RANK_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         num_dims_ff   <= RST_NUM_DIMS;
         dim_sizes_ff  <= RST_DIM_SIZES;
         own_coords_ff <= '0;
         periodic_ff   <= '0;
         own_rank_ff   <= '0;
      end else begin
         num_dims_ff   <= num_dims_in;
         dim_sizes_ff  <= dim_sizes_in;
         own_coords_ff <= own_coords_in;
         periodic_ff   <= periodic_in;
         own_rank_ff   <= own_rank_in;
      end
   end

   // Read back
   always_comb begin
      case (reg_index)
         REG_NUM_DIMS:      prdata = CFG_BITS'(num_dims_ff);
         REG_DIM_SIZES:     prdata = dim_sizes_ff;
         REG_OWN_COORDS:    prdata = own_coords_ff;
         REG_PERIODIC_MASK: prdata = CFG_BITS'(periodic_ff);
         REG_OWN_RANK:      prdata = CFG_BITS'(own_rank_ff);
         default:           prdata = '0;
      endcase
   end

   // ------------------------------------------------------------------
   // Unpack sizes and coordinates; a zero size counts as one
   // ------------------------------------------------------------------
   coord_type size_slot  [SLOT_CNT];
   coord_type coord_slot [DIR_CNT];

   always_comb begin : unpack
      logic [CFG_BITS-1:0] word;
      word = '0;
      for (int i = 0; i < SLOT_CNT; i++) begin
         word = dim_sizes_ff >> (i * COORD_BITS);
         size_slot[i] = (word[COORD_BITS-1:0] == '0) ? coord_type'(1)
                                                     : word[COORD_BITS-1:0];
      end
      for (int i = 0; i < DIR_CNT; i++) begin
         word = own_coords_ff >> (i * COORD_BITS);
         coord_slot[i] = word[COORD_BITS-1:0];
      end
   end

   // ------------------------------------------------------------------
   // Pipeline
   // ------------------------------------------------------------------
   stage_type               pipe_ff [NUM_STAGES];
   stage_type               pipe_in [NUM_STAGES];
   logic [NUM_STAGES-1:0]   valid_ff, valid_in;
   logic [NUM_STAGES-1:0]   adv;

   function automatic side_type side_init(input logic [TGT_BITS-1:0] tgt,
                                          input coord_type size,
                                          input rank_type delta);
      side_type            s;
      logic [TGT_BITS-1:0] mag_full;
      mag_full  = tgt[TGT_BITS-1] ? (TGT_BITS'(0) - tgt) : tgt;
      s.neg     = tgt[TGT_BITS-1];
      s.mag     = mag_full[MAG_BITS-1:0];
      s.rem     = '0;
      s.inrange = !tgt[TGT_BITS-1] && (tgt < TGT_BITS'(size));
      s.delta   = delta;
      s.ok      = 1'b0;
      return s;
   endfunction

   // Wrapped coordinate minus own coordinate, or the plain displacement
   function automatic rank_type side_delta(input side_type s,
                                           input coord_type size,
                                           input coord_type coord,
                                           input logic per);
      coord_type r;
      if (s.neg) begin
         r = (s.rem == '0) ? '0 : size - s.rem;
      end else begin
         r = s.rem;
      end
      return per ? (RANK_BITS'(r) - RANK_BITS'(coord)) : s.delta;
   endfunction

   // Entry: select the dimension, form both shifted coordinates
   always_comb begin : entry
      logic [NDIM_BITS:0]       num_w;
      logic [NDIM_BITS:0]       n_eff;
      logic [SLOT_IDX_BITS-1:0] dir_w;
      logic [SLOT_IDX_BITS-1:0] idx;
      logic [TGT_BITS-1:0]      coord_ext;
      logic [TGT_BITS-1:0]      disp_ext;
      logic [DISP_BITS-1:0]     disp_neg;
      num_w     = {1'b0, num_dims_ff};
      n_eff     = (num_w > (NDIM_BITS+1)'(GRID_DIM_MAX)) ? (NDIM_BITS+1)'(GRID_DIM_MAX)
                                                         : num_w;
      dir_w     = SLOT_IDX_BITS'(req_direction);
      disp_neg  = DISP_BITS'(0) - req_displacement;
      coord_ext = TGT_BITS'(coord_slot[req_direction]);
      disp_ext  = {{(TGT_BITS-DISP_BITS){req_displacement[DISP_BITS-1]}},
                   req_displacement};

      pipe_in[0].dirok  = (NDIM_BITS+1)'(req_direction) < n_eff;
      pipe_in[0].per    = periodic_ff[req_direction];
      pipe_in[0].coord  = coord_slot[req_direction];
      pipe_in[0].size   = size_slot[dir_w];
      pipe_in[0].stride = rank_type'(1);
      for (int k = 0; k < FAC_CNT; k++) begin
         idx = dir_w + SLOT_IDX_BITS'(k + 1);
         pipe_in[0].fac[k] = (idx < SLOT_IDX_BITS'(n_eff)) ? size_slot[idx]
                                                          : coord_type'(1);
      end
      pipe_in[0].src = side_init(coord_ext - disp_ext, size_slot[dir_w],
                                 disp_neg[RANK_BITS-1:0]);
      pipe_in[0].dst = side_init(coord_ext + disp_ext, size_slot[dir_w],
                                 req_displacement[RANK_BITS-1:0]);
   end

   // Remainder stages, with the stride product built alongside
   for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_div
      coord_type rem_src, rem_dst;
      rank_type  stride_nxt;

      crs_rem_step u_src (
         .rem_cur  (pipe_ff[k-1].src.rem),
         .bits_cur (pipe_ff[k-1].src.mag[MAG_BITS-1 -: REM_STEP]),
         .size_cur (pipe_ff[k-1].size),
         .rem_nxt  (rem_src)
      );

      crs_rem_step u_dst (
         .rem_cur  (pipe_ff[k-1].dst.rem),
         .bits_cur (pipe_ff[k-1].dst.mag[MAG_BITS-1 -: REM_STEP]),
         .size_cur (pipe_ff[k-1].size),
         .rem_nxt  (rem_dst)
      );

      if (k <= FAC_CNT) begin : g_mul
         logic [RANK_BITS+COORD_BITS-1:0] prod;
         assign prod = (RANK_BITS+COORD_BITS)'(pipe_ff[k-1].stride)
                     * (RANK_BITS+COORD_BITS)'(pipe_ff[k-1].fac[k-1]);
         assign stride_nxt = prod[RANK_BITS-1:0];
      end else begin : g_hold
         assign stride_nxt = pipe_ff[k-1].stride;
      end

      always_comb begin
         pipe_in[k]         = pipe_ff[k-1];
         pipe_in[k].src.rem = rem_src;
         pipe_in[k].dst.rem = rem_dst;
         pipe_in[k].src.mag = pipe_ff[k-1].src.mag << REM_STEP;
         pipe_in[k].dst.mag = pipe_ff[k-1].dst.mag << REM_STEP;
         pipe_in[k].stride  = stride_nxt;
      end
   end

   // Fixup: finish the wrap, pick the delta, settle validity
   always_comb begin
      pipe_in[FIX_STAGE]           = pipe_ff[FIX_STAGE-1];
      pipe_in[FIX_STAGE].src.delta = side_delta(pipe_ff[FIX_STAGE-1].src,
                                                pipe_ff[FIX_STAGE-1].size,
                                                pipe_ff[FIX_STAGE-1].coord,
                                                pipe_ff[FIX_STAGE-1].per);
      pipe_in[FIX_STAGE].dst.delta = side_delta(pipe_ff[FIX_STAGE-1].dst,
                                                pipe_ff[FIX_STAGE-1].size,
                                                pipe_ff[FIX_STAGE-1].coord,
                                                pipe_ff[FIX_STAGE-1].per);
      pipe_in[FIX_STAGE].src.ok = pipe_ff[FIX_STAGE-1].dirok &&
                                  (pipe_ff[FIX_STAGE-1].per ||
                                   pipe_ff[FIX_STAGE-1].src.inrange);
      pipe_in[FIX_STAGE].dst.ok = pipe_ff[FIX_STAGE-1].dirok &&
                                  (pipe_ff[FIX_STAGE-1].per ||
                                   pipe_ff[FIX_STAGE-1].dst.inrange);
   end

   // Scale the delta by the stride
   always_comb begin
      pipe_in[MUL_STAGE]           = pipe_ff[MUL_STAGE-1];
      pipe_in[MUL_STAGE].src.delta = pipe_ff[MUL_STAGE-1].src.delta
                                   * pipe_ff[MUL_STAGE-1].stride;
      pipe_in[MUL_STAGE].dst.delta = pipe_ff[MUL_STAGE-1].dst.delta
                                   * pipe_ff[MUL_STAGE-1].stride;
   end

   // Add the own rank; a null process reads zero
   always_comb begin
      pipe_in[ADD_STAGE]           = pipe_ff[ADD_STAGE-1];
      pipe_in[ADD_STAGE].src.delta = pipe_ff[ADD_STAGE-1].src.ok
                                   ? own_rank_ff + pipe_ff[ADD_STAGE-1].src.delta
                                   : '0;
      pipe_in[ADD_STAGE].dst.delta = pipe_ff[ADD_STAGE-1].dst.ok
                                   ? own_rank_ff + pipe_ff[ADD_STAGE-1].dst.delta
                                   : '0;
   end

   // Advance a stage when it is empty or its successor advances
   assign adv[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || !rsp_stall;
   for (genvar k = 0; k < NUM_STAGES - 1; k++) begin : g_adv
      assign adv[k] = !valid_ff[k] || adv[k+1];
   end

   assign valid_in = {valid_ff[NUM_STAGES-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NUM_STAGES; k++) begin
            if (adv[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   // Payload moves with its valid bit
   always_ff @(posedge clock) begin
      for (int k = 0; k < NUM_STAGES; k++) begin
         if (adv[k]) begin
            pipe_ff[k] <= pipe_in[k];
         end
      end
   end

   assign req_stall        = !adv[0];
   assign rsp_valid        = valid_ff[NUM_STAGES-1];
   assign rsp_source_rank  = pipe_ff[NUM_STAGES-1].src.delta;
   assign rsp_source_valid = pipe_ff[NUM_STAGES-1].src.ok;
   assign rsp_dest_rank    = pipe_ff[NUM_STAGES-1].dst.delta;
   assign rsp_dest_valid   = pipe_ff[NUM_STAGES-1].dst.ok;

`ifndef NO_ASSERTIONS
   // Requests are held off only with every stage full and the output stalled
   a_stall_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> ((&valid_ff) && rsp_stall))
      else $error("request stalled with room in the pipeline");

   // A free output lets the whole pipe move
   a_free_flow: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("request stalled while the response side is free");

   // A null source reads rank zero
   a_null_source: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_source_valid) |-> (rsp_source_rank == '0))
      else $error("null source carries a nonzero rank");

   // A null destination reads rank zero
   a_null_dest: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_dest_valid) |-> (rsp_dest_rank == '0))
      else $error("null destination carries a nonzero rank");
`endif

endmodule

/* tb/sv/tb.sv */
module tb;
   import crs_pkg::*;

   localparam int QUIET_LIMIT = 4000;
   localparam int HOLD_CYCLES = 80;

   // One shift request as the sender presents it
   typedef struct packed {
      logic [DIR_BITS-1:0]         dir;
      logic signed [DISP_BITS-1:0] disp;
   } shift_req_type;

   // Expected neighbor pair for one request
   typedef struct packed {
      logic [RANK_BITS-1:0] src_rank;
      logic                 src_ok;
      logic [RANK_BITS-1:0] dst_rank;
      logic                 dst_ok;
   } neighbor_ranks_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                        req_valid = 1'b0;
   logic                        req_stall;
   logic [DIR_BITS-1:0]         req_direction = '0;
   logic signed [DISP_BITS-1:0] req_displacement = '0;
   logic                        rsp_valid;
   logic                        rsp_stall = 1'b0;
   logic [RANK_BITS-1:0]        rsp_source_rank;
   logic                        rsp_source_valid;
   logic [RANK_BITS-1:0]        rsp_dest_rank;
   logic                        rsp_dest_valid;
   logic                        psel = 1'b0;
   logic                        penable = 1'b0;
   logic                        pwrite = 1'b0;
   logic [ADDR_BITS-1:0]        paddr = '0;
   logic [CFG_BITS-1:0]         pwdata = '0;
   logic [CFG_BITS-1:0]         prdata;
   logic                        pready;

   // Grid registers as the predictor sees them
   logic [NDIM_BITS-1:0]     grid_ndims  = RST_NUM_DIMS;
   logic [CFG_BITS-1:0]      grid_sizes  = RST_DIM_SIZES;
   logic [CFG_BITS-1:0]      grid_coords = '0;
   logic [PERIODIC_BITS-1:0] grid_wrap   = '0;
   logic [RANK_BITS-1:0]     grid_rank   = '0;

   shift_req_type      pending_shifts[$];
   neighbor_ranks_type expected_ranks[$];

   int   shifts_loaded  = 0;
   int   results_taken  = 0;
   int   mismatch_count = 0;
   int   send_gap       = 0;
   int   stall_burst    = 0;
   int   hold_left      = 0;
   logic hold_done      = 1'b0;
   logic hold_ask       = 1'b0;
   logic calm           = 1'b0;
   logic req_took       = 1'b0;

   cartesian_rank_shift_top dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_direction(req_direction), .req_displacement(req_displacement),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_source_rank(rsp_source_rank), .rsp_source_valid(rsp_source_valid),
      .rsp_dest_rank(rsp_dest_rank), .rsp_dest_valid(rsp_dest_valid),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   always #5 clock = ~clock;

   // Size of one dimension; a zero field counts as one
   function automatic longint unsigned size_at(input int unsigned idx);
      longint unsigned s;
      s = {48'd0, grid_sizes[idx*COORD_BITS +: COORD_BITS]};
      return (s == 0) ? 1 : s;
   endfunction

   // Rank of the neighbor at offset d along dimension dir
   function automatic void shift_one(input int unsigned dir, input longint d,
                                     input longint unsigned stride,
                                     output logic [RANK_BITS-1:0] rank,
                                     output logic ok);
      longint c, s, tgt, r, delta;
      longint unsigned sum;
      c   = {48'd0, grid_coords[dir*COORD_BITS +: COORD_BITS]};
      s   = size_at(dir);
      tgt = c + d;
      if (grid_wrap[dir]) begin
         r = tgt % s;
         if (r < 0) r += s;
         delta = r - c;
      end else if (tgt < 0 || tgt >= s) begin
         rank = '0;
         ok   = 1'b0;
         return;
      end else begin
         delta = d;
      end
      sum  = {32'd0, grid_rank} + delta * stride;
      rank = sum[RANK_BITS-1:0];
      ok   = 1'b1;
   endfunction

   // Source and destination ranks for one shift request
   function automatic neighbor_ranks_type predict_neighbors(
         input logic [DIR_BITS-1:0] dir, input logic signed [DISP_BITS-1:0] disp);
      neighbor_ranks_type res;
      int unsigned n, i;
      longint unsigned stride;
      longint d;
      res = '0;
      d   = disp;
      n   = (grid_ndims > GRID_DIM_MAX) ? GRID_DIM_MAX : grid_ndims;
      if (dir < n) begin
         stride = 1;
         for (i = dir + 1; i < n; i++) stride *= size_at(i);
         shift_one(dir, -d, stride, res.src_rank, res.src_ok);
         shift_one(dir, d, stride, res.dst_rank, res.dst_ok);
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
   endtask

   // Register write: setup cycle, then access cycle until pready
   task automatic csr_write(input logic [REG_IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= val;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      case (idx)
         REG_NUM_DIMS:      grid_ndims  = val[NDIM_BITS-1:0];
         REG_DIM_SIZES:     grid_sizes  = val;
         REG_OWN_COORDS:    grid_coords = val;
         REG_PERIODIC_MASK: grid_wrap   = val[PERIODIC_BITS-1:0];
         REG_OWN_RANK:      grid_rank   = val[RANK_BITS-1:0];
         default: ;
      endcase
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic set_grid(input logic [NDIM_BITS-1:0] nd, input logic [CFG_BITS-1:0] sizes,
                           input logic [CFG_BITS-1:0] coords,
                           input logic [PERIODIC_BITS-1:0] wrap,
                           input logic [RANK_BITS-1:0] rank);
      csr_write(REG_NUM_DIMS, {61'd0, nd});
      csr_write(REG_DIM_SIZES, sizes);
      csr_write(REG_OWN_COORDS, coords);
      csr_write(REG_PERIODIC_MASK, {60'd0, wrap});
      csr_write(REG_OWN_RANK, {32'd0, rank});
   endtask

   task automatic add_shift(input logic [DIR_BITS-1:0] dir, input logic [DISP_BITS-1:0] disp);
      shift_req_type r;
      r.dir  = dir;
      r.disp = disp;
      pending_shifts.push_back(r);
      shifts_loaded++;
   endtask

   // Wait until every loaded request has come back
   task automatic drain_results();
      while (results_taken < shifts_loaded) @(negedge clock);
   endtask

   // Random grid: mostly small sizes, some zero or full-width ones
   task automatic load_random_grid();
      logic [CFG_BITS-1:0]   sizes, coords;
      logic [NDIM_BITS-1:0]  nd;
      logic [COORD_BITS-1:0] sz;
      sizes  = '0;
      coords = '0;
      for (int i = 0; i < GRID_DIM_MAX; i++) begin
         case ($urandom_range(0, 7))
            0:       sz = '0;
            1:       sz = COORD_BITS'($urandom);
            default: sz = COORD_BITS'($urandom_range(1, 6));
         endcase
         sizes[i*COORD_BITS +: COORD_BITS] = sz;
         if ($urandom_range(0, 9) == 0)
            coords[i*COORD_BITS +: COORD_BITS] = COORD_BITS'($urandom);
         else
            coords[i*COORD_BITS +: COORD_BITS] = COORD_BITS'($urandom % (sz == 0 ? 1 : sz));
      end
      nd = ($urandom_range(0, 7) == 0) ? NDIM_BITS'($urandom_range(0, 7))
                                       : NDIM_BITS'($urandom_range(1, GRID_DIM_MAX));
      set_grid(nd, sizes, coords, PERIODIC_BITS'($urandom), $urandom);
   endtask

   // Displacement: mostly small, some around the size, some full range
   function automatic logic [DISP_BITS-1:0] pick_displacement(input int unsigned dir);
      int s;
      s = int'(size_at(dir));
      case ($urandom_range(0, 9))
         0: return $urandom;
         1: begin
            case ($urandom_range(0, 3))
               0:       return 32'h7FFF_FFFF;
               1:       return 32'h8000_0000;
               2:       return 32'hFFFF_FFFF;
               default: return 32'h0;
            endcase
         end
         2: return ($urandom_range(0, 1) ? s : -s) + $urandom_range(0, 2) - 1;
         default: return $urandom_range(0, 16) - 8;
      endcase
   endfunction

   // Sender: hold until taken, then idle a burst or present the next request
   always @(negedge clock) begin
      shift_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (req_valid && !req_took) begin
         // hold the stalled request
      end else if (send_gap > 0) begin
         req_valid <= 1'b0;
         send_gap  <= send_gap - 1;
      end else if (pending_shifts.size() > 0) begin
         nxt = pending_shifts.pop_front();
         req_direction    <= nxt.dir;
         req_displacement <= nxt.disp;
         req_valid        <= 1'b1;
         if (!calm && $urandom_range(0, 7) == 0) send_gap <= $urandom_range(1, 14);
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Receiver: one long hold-off on request, otherwise random stall bursts
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_ask && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (stall_burst > 0) begin
         rsp_stall   <= 1'b1;
         stall_burst <= stall_burst - 1;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
         rsp_stall   <= 1'b1;
         stall_burst <= $urandom_range(0, 13);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Check responses against the oldest expectation, predict on each request
   always @(posedge clock) begin
      neighbor_ranks_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            results_taken++;
            if (expected_ranks.size() == 0) begin
               report_mismatch("response with none expected", rsp_source_rank, 0);
            end else begin
               want = expected_ranks.pop_front();
               if (rsp_source_rank !== want.src_rank)
                  report_mismatch("source_rank", rsp_source_rank, want.src_rank);
               if (rsp_source_valid !== want.src_ok)
                  report_mismatch("source_valid", rsp_source_valid, want.src_ok);
               if (rsp_dest_rank !== want.dst_rank)
                  report_mismatch("dest_rank", rsp_dest_rank, want.dst_rank);
               if (rsp_dest_valid !== want.dst_ok)
                  report_mismatch("dest_valid", rsp_dest_valid, want.dst_ok);
            end
         end
         if (req_valid && !req_stall)
            expected_ranks.push_back(predict_neighbors(req_direction, req_displacement));
      end
      req_took <= !reset && req_valid && !req_stall;
   end

   // Watchdog: end the run after a long stretch with no handshake
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (psel && penable))
            quiet = 0;
         else
            quiet++;
      end
      $display("Regression FAIL");
      $finish;
   end

   initial begin : stimulus
      int unsigned dir;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset grid: one dimension of size one
      add_shift(0, 0);
      add_shift(0, 1);
      add_shift(1, -1);
      add_shift(3, 32'h7FFF_FFFF);
      drain_results();

      // saturated dimension count, zero size, out-of-range coordinate, rank wrap
      set_grid(3'd7, 64'hFFFF_0005_0000_0003, 64'hFFFF_0004_0009_0002, 4'b0101,
               32'hFFFF_FFF0);
      add_shift(0, 1);
      add_shift(0, -1);
      add_shift(0, 32'h8000_0000);
      add_shift(1, 1);
      add_shift(1, -9);
      add_shift(2, 3);
      add_shift(2, -13);
      add_shift(3, -1);
      add_shift(3, 32'h7FFF_FFFF);
      add_shift(3, 0);
      drain_results();

      // no dimensions in use
      set_grid(3'd0, 64'h0003_0003_0003_0003, '0, 4'hF, 32'd17);
      add_shift(0, 5);
      add_shift(2, -5);
      add_shift(3, 0);
      drain_results();

      // random grids, then two fixed ones; one long receiver hold-off, quiet tail
      for (int ph = 0; ph < 14; ph++) begin
         if (ph == 12)
            set_grid(3'd4, 64'hFFFF_FFFF_FFFF_FFFF, {$urandom, $urandom}, 4'hF,
                     32'hFFFF_FFFF);
         else if (ph == 13)
            set_grid(3'd4, 64'h0002_0003_0004_0005, 64'h0001_0002_0003_0004, 4'h0, 32'd0);
         else
            load_random_grid();
         calm     = (ph >= 12);
         hold_ask = (ph == 4);
         for (int k = 0; k < 50; k++) begin
            dir = $urandom_range(0, DIR_CNT - 1);
            add_shift(DIR_BITS'(dir), pick_displacement(dir));
         end
         drain_results();
      end

      repeat (2 * NUM_STAGES) @(posedge clock);
      if (expected_ranks.size() != 0)
         report_mismatch("requests left without response", expected_ranks.size(), 0);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/crs_pkg.sv
sv/crs_rem_step.sv
sv/cartesian_rank_shift_top.sv
tb/sv/tb.sv
